// File: src/linked_job_queue_engine_unit_macros.svh
// ----------------------------------------------------------------------------
// linked_job_queue_engine_unit_macros
// Assertion helpers shared by the job queue RTL.
// Both macros expect a clock named clk and a reset named rst in scope.
// ----------------------------------------------------------------------------
`ifndef LINKED_JOB_QUEUE_ENGINE_UNIT_MACROS_SVH
`define LINKED_JOB_QUEUE_ENGINE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LJQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("job queue assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LJQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("job queue assertion failed");

`endif

// File: src/ljq_pkg.sv
// ----------------------------------------------------------------------------
// ljq_pkg
// Types, sizes and operation codes shared by the linked job queue block.
// ----------------------------------------------------------------------------
package ljq_pkg;

  // Pool size and derived index widths.
  localparam int POOL_SLOTS = 16;
  localparam int SLOT_BITS  = $clog2(POOL_SLOTS);
  localparam int LINK_BITS  = SLOT_BITS + 1;
  localparam int ID_BITS    = 16;

  // A link equal to the pool size means there is no neighbor.
  localparam logic [LINK_BITS-1:0] NIL_LINK = LINK_BITS'(POOL_SLOTS);

  // Operation codes.
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;
  localparam logic [1:0] FUNC_FIND   = 2'd3;

  // Input item.
  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  node_slot;
    logic [15:0] owner_id;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic       status;
    logic       found;
    logic [3:0] match_slot;
  } out_item_t;

  // Write requests into the link store, one port per array.
  typedef struct packed {
    logic                 next_we;
    logic [SLOT_BITS-1:0] next_addr;
    logic [LINK_BITS-1:0] next_data;
    logic                 prev_we;
    logic [SLOT_BITS-1:0] prev_addr;
    logic [LINK_BITS-1:0] prev_data;
    logic                 own_we;
    logic [SLOT_BITS-1:0] own_addr;
    logic [ID_BITS-1:0]   own_data;
  } ljq_wr_t;

  // Registered read data from the link store.
  typedef struct packed {
    logic [LINK_BITS-1:0] next_link;
    logic [LINK_BITS-1:0] prev_link;
    logic [ID_BITS-1:0]   owner;
  } ljq_rd_t;

endpackage

// File: src/linked_job_queue_engine_unit.sv
// ----------------------------------------------------------------------------
// linked_job_queue_engine_unit
// Doubly linked job list over a fixed pool of slots: insert, append, remove
// and find by owner id, one operation at a time under a small sequencer.
// ----------------------------------------------------------------------------
// The block takes one operation at a time and is not ready while it works.
// Insert and append go through S_LINK2 to S_DONE (straight to S_DONE when
// the list is empty), remove through S_RM to S_DONE, and a refused operation
// straight to S_DONE. Find visits at most POOL_SLOTS = 16 slots in S_WALK:
// the walk chases next links through the single read port of the link
// memory, one slot per cycle, with the owner compare done on the registered
// read data. A finished result sits in the output register, so the next
// operation is taken while it waits. There is no clearing pass after reset:
// linked marks in flip-flops guard every read of the link memory.
module linked_job_queue_engine_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ljq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ljq_pkg::out_item_t out_data
);

  `include "linked_job_queue_engine_unit_macros.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LINK2 = 3'd1;
  localparam logic [2:0] S_RM    = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                          state, state_next;
  logic [ljq_pkg::SLOT_BITS-1:0]       head, head_next;
  logic [ljq_pkg::SLOT_BITS-1:0]       tail, tail_next;
  logic                                list_empty, list_empty_next;
  logic [ljq_pkg::POOL_SLOTS-1:0]      linked, linked_next;
  logic [1:0]                          func_q, func_q_next;
  logic [ljq_pkg::SLOT_BITS-1:0]       slot_q, slot_q_next;
  logic [ljq_pkg::ID_BITS-1:0]         id_q, id_q_next;
  logic [ljq_pkg::SLOT_BITS-1:0]       cur, cur_next;
  logic [ljq_pkg::SLOT_BITS-1:0]       steps, steps_next;
  ljq_pkg::out_item_t                  res, res_next;
  logic                                out_valid_next;
  ljq_pkg::out_item_t                  out_data_next;

  ljq_pkg::ljq_wr_t                    wr;
  ljq_pkg::ljq_rd_t                    rd;
  logic [ljq_pkg::SLOT_BITS-1:0]       rd_addr;

  logic [ljq_pkg::SLOT_BITS-1:0]       in_slot;
  logic [ljq_pkg::ID_BITS-1:0]         in_id;
  logic                                in_slot_ok;
  logic                                nx_ok, pv_ok, hit;
  logic [ljq_pkg::SLOT_BITS-1:0]       nx_idx, pv_idx;

  ljq_link_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd      (rd)
  );

  // Decode of the incoming item and of the registered link data.
  assign in_slot    = ljq_pkg::SLOT_BITS'(in_data.node_slot);
  assign in_id      = in_data.owner_id[ljq_pkg::ID_BITS-1:0];
  assign in_slot_ok = (32'(in_data.node_slot) < ljq_pkg::POOL_SLOTS);
  assign nx_ok      = (rd.next_link < ljq_pkg::NIL_LINK);
  assign pv_ok      = (rd.prev_link < ljq_pkg::NIL_LINK);
  assign nx_idx     = rd.next_link[ljq_pkg::SLOT_BITS-1:0];
  assign pv_idx     = rd.prev_link[ljq_pkg::SLOT_BITS-1:0];
  assign hit        = linked[cur] && (rd.owner == id_q);
  assign in_ready   = (state == S_IDLE);

  // Sequencer.
  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    list_empty_next = list_empty;
    linked_next     = linked;
    func_q_next     = func_q;
    slot_q_next     = slot_q;
    id_q_next       = id_q;
    cur_next        = cur;
    steps_next      = steps;
    res_next        = res;
    out_valid_next  = out_valid;
    out_data_next   = out_data;
    wr              = '0;
    rd_addr         = cur;

    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          func_q_next = in_data.func;
          slot_q_next = in_slot;
          id_q_next   = in_id;
          res_next    = '0;
          if (in_data.func == ljq_pkg::FUNC_FIND) begin
            // Start the walk at the head, or finish at once on an empty list.
            if (list_empty) begin
              state_next = S_DONE;
            end else begin
              rd_addr    = head;
              cur_next   = head;
              steps_next = '0;
              state_next = S_WALK;
            end
          end else if (!in_slot_ok) begin
            res_next.status = 1'b1;
            state_next      = S_DONE;
          end else if (in_data.func == ljq_pkg::FUNC_REMOVE) begin
            // Fetch the neighbors of the slot being unlinked.
            if (!linked[in_slot]) begin
              res_next.status = 1'b1;
              state_next      = S_DONE;
            end else begin
              rd_addr    = in_slot;
              state_next = S_RM;
            end
          end else if (linked[in_slot]) begin
            res_next.status = 1'b1;
            state_next      = S_DONE;
          end else begin
            // First link write: the new slot's own fields.
            wr.own_we              = 1'b1;
            wr.own_addr            = in_slot;
            wr.own_data            = in_id;
            wr.next_we             = 1'b1;
            wr.next_addr           = in_slot;
            wr.prev_we             = 1'b1;
            wr.prev_addr           = in_slot;
            linked_next[in_slot]   = 1'b1;
            if (in_data.func == ljq_pkg::FUNC_INSERT) begin
              wr.prev_data = ljq_pkg::NIL_LINK;
              wr.next_data = list_empty ? ljq_pkg::NIL_LINK
                                        : ljq_pkg::LINK_BITS'(head);
            end else begin
              wr.next_data = ljq_pkg::NIL_LINK;
              wr.prev_data = list_empty ? ljq_pkg::NIL_LINK
                                        : ljq_pkg::LINK_BITS'(tail);
            end
            if (list_empty) begin
              head_next       = in_slot;
              tail_next       = in_slot;
              list_empty_next = 1'b0;
              state_next      = S_DONE;
            end else begin
              state_next = S_LINK2;
            end
          end
        end
      end

      S_LINK2: begin
        // Second link write: point the old end back at the new slot.
        if (func_q == ljq_pkg::FUNC_INSERT) begin
          wr.prev_we   = 1'b1;
          wr.prev_addr = head;
          wr.prev_data = ljq_pkg::LINK_BITS'(slot_q);
          head_next    = slot_q;
        end else begin
          wr.next_we   = 1'b1;
          wr.next_addr = tail;
          wr.next_data = ljq_pkg::LINK_BITS'(slot_q);
          tail_next    = slot_q;
        end
        state_next = S_DONE;
      end

      S_RM: begin
        // Bridge the neighbors around the removed slot.
        if (pv_ok) begin
          wr.next_we   = 1'b1;
          wr.next_addr = pv_idx;
          wr.next_data = rd.next_link;
        end else begin
          head_next = nx_ok ? nx_idx : '0;
        end
        if (nx_ok) begin
          wr.prev_we   = 1'b1;
          wr.prev_addr = nx_idx;
          wr.prev_data = rd.prev_link;
        end else begin
          tail_next = pv_ok ? pv_idx : '0;
        end
        if (!pv_ok && !nx_ok) begin
          list_empty_next = 1'b1;
          head_next       = '0;
          tail_next       = '0;
        end
        linked_next[slot_q] = 1'b0;
        state_next          = S_DONE;
      end

      S_WALK: begin
        // One slot per cycle: compare its owner, then follow its next link.
        if (hit) begin
          res_next.found      = 1'b1;
          res_next.match_slot = 4'(cur);
          state_next          = S_DONE;
        end else if (!nx_ok ||
                     steps == ljq_pkg::SLOT_BITS'(ljq_pkg::POOL_SLOTS - 1)) begin
          state_next = S_DONE;
        end else begin
          rd_addr    = nx_idx;
          cur_next   = nx_idx;
          steps_next = steps + 1'b1;
        end
      end

      S_DONE: begin
        // Hand the result to the output register once it is free.
        if (!out_valid || out_ready) begin
          out_data_next  = res;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      list_empty <= 1'b1;
      linked     <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      tail       <= tail_next;
      list_empty <= list_empty_next;
      linked     <= linked_next;
      out_valid  <= out_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    func_q   <= func_q_next;
    slot_q   <= slot_q_next;
    id_q     <= id_q_next;
    cur      <= cur_next;
    steps    <= steps_next;
    res      <= res_next;
    out_data <= out_data_next;
  end

  // An empty list has no linked slots.
  `LJQ_ASSERT_IMPL(a_empty_no_links, list_empty, linked == '0)
  // Between operations both ends of a non-empty list are linked slots.
  `LJQ_ASSERT_IMPL(a_ends_linked, !list_empty && state == S_IDLE, linked[head] && linked[tail])
  // Only one operation is in flight at a time.
  `LJQ_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)
  // A walk only runs over a non-empty list.
  `LJQ_ASSERT_IMPL(a_walk_nonempty, state == S_WALK, !list_empty)

endmodule

// File: src/ljq_link_store.sv
// ----------------------------------------------------------------------------
// ljq_link_store
// Next links, previous links and owner ids of the slot pool, each a memory
// with one write port; all three share one read address and a registered read.
// ----------------------------------------------------------------------------
module ljq_link_store (
  input  logic                          clk,
  input  ljq_pkg::ljq_wr_t              wr,
  input  logic [ljq_pkg::SLOT_BITS-1:0] rd_addr,
  output ljq_pkg::ljq_rd_t              rd
);

  logic [ljq_pkg::LINK_BITS-1:0] next_mem [ljq_pkg::POOL_SLOTS];
  logic [ljq_pkg::LINK_BITS-1:0] prev_mem [ljq_pkg::POOL_SLOTS];
  logic [ljq_pkg::ID_BITS-1:0]   own_mem  [ljq_pkg::POOL_SLOTS];

  // Writes land at the clock edge.
  always_ff @(posedge clk) begin
    if (wr.next_we) begin
      next_mem[wr.next_addr] <= wr.next_data;
    end
    if (wr.prev_we) begin
      prev_mem[wr.prev_addr] <= wr.prev_data;
    end
    if (wr.own_we) begin
      own_mem[wr.own_addr] <= wr.own_data;
    end
  end

  // Read data is registered and available in the cycle after the address.
  always_ff @(posedge clk) begin
    rd.next_link <= next_mem[rd_addr];
    rd.prev_link <= prev_mem[rd_addr];
    rd.owner     <= own_mem[rd_addr];
  end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// Linked job queue testbench
// Drives insert, append, remove and find operations into the job list block,
// predicts each reply from a private copy of the list, and checks every reply
// field by field. Both sides idle at random, and the receiver holds off once
// long enough that the block stalls its input.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Scoreboard: keeps its own copy of the list and the replies still owed.
  class job_list_model;
    logic [3:0]          first_slot;
    logic [3:0]          last_slot;
    bit                  is_empty;
    logic [4:0]          fwd_link [ljq_pkg::POOL_SLOTS];
    logic [4:0]          back_link [ljq_pkg::POOL_SLOTS];
    logic [15:0]         slot_id [ljq_pkg::POOL_SLOTS];
    bit                  in_list [ljq_pkg::POOL_SLOTS];
    ljq_pkg::out_item_t  expected_replies [$];
    int                  fail_count;

    function new();
      first_slot = '0;
      last_slot  = '0;
      is_empty   = 1'b1;
      fail_count = 0;
      foreach (in_list[k]) begin
        in_list[k]   = 1'b0;
        fwd_link[k]  = ljq_pkg::NIL_LINK;
        back_link[k] = ljq_pkg::NIL_LINK;
        slot_id[k]   = '0;
      end
    endfunction

    // Picks a slot that is (or is not) on the list; any slot if none fits.
    function logic [3:0] pick_slot(bit want_linked);
      logic [3:0] cands [$];
      for (int k = 0; k < ljq_pkg::POOL_SLOTS; k++) begin
        if (in_list[k] == want_linked) cands.push_back(4'(k));
      end
      if (cands.size() == 0) return 4'($urandom_range(15));
      return cands[$urandom_range(cands.size() - 1)];
    endfunction

    // Applies one operation to the list copy and returns the reply it gives.
    function ljq_pkg::out_item_t apply_job(ljq_pkg::in_item_t job);
      ljq_pkg::out_item_t rep;
      logic [3:0]         s;
      logic [4:0]         cur;
      logic [4:0]         nx;
      logic [4:0]         pv;
      rep = '0;
      s = job.node_slot;
      if (job.func == ljq_pkg::FUNC_FIND) begin
        // Walk from the head, at most one pass over the pool.
        cur = is_empty ? ljq_pkg::NIL_LINK : {1'b0, first_slot};
        for (int n = 0; n < ljq_pkg::POOL_SLOTS && cur != ljq_pkg::NIL_LINK; n++) begin
          if (in_list[cur[3:0]] && slot_id[cur[3:0]] == job.owner_id) begin
            rep.found      = 1'b1;
            rep.match_slot = cur[3:0];
            break;
          end
          cur = fwd_link[cur[3:0]];
        end
      end else if (job.func == ljq_pkg::FUNC_REMOVE) begin
        if (!in_list[s]) begin
          rep.status = 1'b1;
        end else begin
          nx = fwd_link[s];
          pv = back_link[s];
          if (pv != ljq_pkg::NIL_LINK) fwd_link[pv[3:0]] = nx;
          else first_slot = (nx != ljq_pkg::NIL_LINK) ? nx[3:0] : 4'd0;
          if (nx != ljq_pkg::NIL_LINK) back_link[nx[3:0]] = pv;
          else last_slot = (pv != ljq_pkg::NIL_LINK) ? pv[3:0] : 4'd0;
          if (pv == ljq_pkg::NIL_LINK && nx == ljq_pkg::NIL_LINK) begin
            is_empty   = 1'b1;
            first_slot = '0;
            last_slot  = '0;
          end
          in_list[s] = 1'b0;
        end
      end else if (in_list[s]) begin
        // Linking a slot that is already on the list is refused.
        rep.status = 1'b1;
      end else begin
        slot_id[s] = job.owner_id;
        if (job.func == ljq_pkg::FUNC_INSERT) begin
          back_link[s] = ljq_pkg::NIL_LINK;
          if (is_empty) begin
            fwd_link[s] = ljq_pkg::NIL_LINK;
            last_slot   = s;
          end else begin
            fwd_link[s]            = {1'b0, first_slot};
            back_link[first_slot]  = {1'b0, s};
          end
          first_slot = s;
        end else begin
          fwd_link[s] = ljq_pkg::NIL_LINK;
          if (is_empty) begin
            back_link[s] = ljq_pkg::NIL_LINK;
            first_slot   = s;
          end else begin
            back_link[s]        = {1'b0, last_slot};
            fwd_link[last_slot] = {1'b0, s};
          end
          last_slot = s;
        end
        is_empty   = 1'b0;
        in_list[s] = 1'b1;
      end
      return rep;
    endfunction

    // Notes an accepted operation and queues the reply it must produce.
    function void note_job(ljq_pkg::in_item_t job);
      expected_replies.push_back(apply_job(job));
    endfunction

    // Compares one accepted reply with the oldest one owed.
    function void check_reply(ljq_pkg::out_item_t got);
      ljq_pkg::out_item_t want;
      if (expected_replies.size() == 0) begin
        $error("reply transfer with none expected: %p", got);
        fail_count++;
        return;
      end
      want = expected_replies.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        fail_count++;
      end
      if (got.found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, got.found);
        fail_count++;
      end
      if (got.match_slot !== want.match_slot) begin
        $error("match_slot: expected %0d, actual %0d", want.match_slot, got.match_slot);
        fail_count++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  ljq_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  ljq_pkg::out_item_t out_data;

  job_list_model sb = new();
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_off_req;
  logic [15:0] id_pool [8] = '{16'h0000, 16'hFFFF, 16'h1234, 16'hAAAA,
                               16'h5555, 16'h00FF, 16'h8001, 16'h7E7E};

  linked_job_queue_engine_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic ljq_pkg::in_item_t job_item(logic [1:0] f, logic [3:0] s,
                                                 logic [15:0] id);
    ljq_pkg::in_item_t job;
    job.func      = f;
    job.node_slot = s;
    job.owner_id  = id;
    return job;
  endfunction

  // Random operation: mostly well-formed links, removes and finds, with some
  // refused ones mixed in. While growing, links win; otherwise removes do.
  function automatic ljq_pkg::in_item_t make_job(bit grow);
    ljq_pkg::in_item_t job;
    int                roll;
    int                pick;
    roll = $urandom_range(99);
    pick = $urandom_range(99);
    job.owner_id  = (pick < 50) ? id_pool[$urandom_range(7)] : 16'($urandom);
    job.node_slot = 4'($urandom_range(15));
    if (roll < 25) begin
      job.func = ljq_pkg::FUNC_FIND;
      if (pick < 60) job.owner_id = sb.slot_id[sb.pick_slot(1'b1)];
    end else if (roll < 33) begin
      job.func = 2'($urandom_range(2));
    end else if ($urandom_range(99) < (grow ? 75 : 30)) begin
      job.func      = $urandom_range(1) ? ljq_pkg::FUNC_APPEND : ljq_pkg::FUNC_INSERT;
      job.node_slot = sb.pick_slot(1'b0);
    end else begin
      job.func      = ljq_pkg::FUNC_REMOVE;
      job.node_slot = sb.pick_slot(1'b1);
    end
    return job;
  endfunction

  // Offers one operation, idling first at random, and returns at its transfer.
  task automatic send_job(ljq_pkg::in_item_t job);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= job;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_job(job);
  endtask

  // Reply side: checks each transfer and stalls at random, once for long.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_reply(out_data);
      if (hold_off_req) begin
        hold_left    = 150;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Main sequence.
  initial begin
    ljq_pkg::in_item_t opening [$];
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    hold_off_req  = 1'b0;
    send_idle_pct = 23;
    recv_idle_pct = 70;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty list, refusals, head, tail and middle removal,
    // duplicate ids and extreme field values.
    opening.push_back(job_item(ljq_pkg::FUNC_FIND,   4'd0,  16'h0000));
    opening.push_back(job_item(ljq_pkg::FUNC_REMOVE, 4'd3,  16'h0000));
    opening.push_back(job_item(ljq_pkg::FUNC_INSERT, 4'd0,  16'h0000));
    opening.push_back(job_item(ljq_pkg::FUNC_APPEND, 4'd15, 16'hFFFF));
    opening.push_back(job_item(ljq_pkg::FUNC_INSERT, 4'd0,  16'h1234));
    opening.push_back(job_item(ljq_pkg::FUNC_APPEND, 4'd15, 16'h1234));
    opening.push_back(job_item(ljq_pkg::FUNC_FIND,   4'd5,  16'hFFFF));
    opening.push_back(job_item(ljq_pkg::FUNC_FIND,   4'd15, 16'h0000));
    opening.push_back(job_item(ljq_pkg::FUNC_FIND,   4'd0,  16'h1234));
    opening.push_back(job_item(ljq_pkg::FUNC_APPEND, 4'd7,  16'hAAAA));
    opening.push_back(job_item(ljq_pkg::FUNC_INSERT, 4'd8,  16'h5555));
    opening.push_back(job_item(ljq_pkg::FUNC_INSERT, 4'd9,  16'hAAAA));
    opening.push_back(job_item(ljq_pkg::FUNC_FIND,   4'd0,  16'hAAAA));
    opening.push_back(job_item(ljq_pkg::FUNC_REMOVE, 4'd15, 16'hFFFF));
    opening.push_back(job_item(ljq_pkg::FUNC_REMOVE, 4'd9,  16'h0000));
    opening.push_back(job_item(ljq_pkg::FUNC_REMOVE, 4'd7,  16'h0000));
    opening.push_back(job_item(ljq_pkg::FUNC_REMOVE, 4'd7,  16'h0000));
    opening.push_back(job_item(ljq_pkg::FUNC_FIND,   4'd0,  16'hAAAA));
    opening.push_back(job_item(ljq_pkg::FUNC_REMOVE, 4'd8,  16'h0000));
    opening.push_back(job_item(ljq_pkg::FUNC_REMOVE, 4'd0,  16'h0000));
    opening.push_back(job_item(ljq_pkg::FUNC_FIND,   4'd0,  16'h5555));
    opening.push_back(job_item(ljq_pkg::FUNC_APPEND, 4'd3,  16'h0F0F));
    opening.push_back(job_item(ljq_pkg::FUNC_REMOVE, 4'd3,  16'h0000));
    foreach (opening[k]) send_job(opening[k]);

    // Random part in three idling phases; the long receiver hold comes first
    // in the phase without idling.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 70 : 0;
      recv_idle_pct = (ph == 0) ? 70 : (ph == 1) ? 23 : 0;
      if (ph == 2) hold_off_req = 1'b1;
      for (int n = 0; n < 210; n++) send_job(make_job(((n / 50) % 2) == 0));
    end
    in_valid <= 1'b0;

    // Drain, then allow for any stray reply.
    while (sb.expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_replies.size() != 0) begin
      $error("%0d replies never arrived", sb.expected_replies.size());
      sb.fail_count++;
    end
    if (sb.fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
